// ===== hw/rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Sizes, operation and status codes, and the control word that the top
// level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY = 64;                      // 2 .. 64
    localparam int IDX_W    = $clog2(CAPACITY);        // cell index width
    localparam int CNT_W    = $clog2(CAPACITY + 1);    // element count width
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd                 cmd;
        logic [IDX_W-1:0]          pos;    // 0-based target of insert / delete
        logic [IDX_W-1:0]          tail;   // index of the last occupied cell
        logic signed [DATA_W-1:0]  value;  // element to insert
    } t_cell_ctl;

endpackage

// ===== hw/rtl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell: one storage cell of the list chain
// Holds one element; loads from its left or right neighbor, the head cell,
// or the insert value, as the broadcast control word selects.
// ----------------------------------------------------------------------------
module pal_cell
    import pal_pkg::*;
(
    input  logic                      i_clk,
    input  logic [IDX_W-1:0]          i_cell_idx,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0]  i_left,
    input  logic signed [DATA_W-1:0]  i_right,
    input  logic signed [DATA_W-1:0]  i_head,
    output logic signed [DATA_W-1:0]  o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                // shift the tail up, store the new element at the target
                if (i_cell_idx > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_cell_idx == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end
            end
            CMD_DELETE: begin
                if (i_cell_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            CMD_ROTATE: begin
                // advance the occupied part by one place, head wraps to tail
                if (i_cell_idx == i_ctl.tail) begin
                    n_data = i_head;
                end else if (i_cell_idx < i_ctl.tail) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/positional_array_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_top: ordered list with insert / delete at position
// A chain of storage cells holds up to CAPACITY signed elements in list
// order; inserts and deletes shift the chain in place, a traverse rotates it.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------
//  in      | i_in_valid  | o_in_stall  | i_operation, i_position, i_value
//  out     | o_out_valid | i_out_stall | o_status, o_element, o_length, o_last
//
//  Insert, delete and every rejected item are done on acceptance: the cell
//  chain shifts in the accept cycle and the result lands in the output
//  register. A traverse of N elements first hands off to the sequencer,
//  which emits the elements from the head cell one by one while the chain
//  rotates by one place each time; after N steps the list is back in order.
//  Reset clears the count, the sequencer and the output valid; cell contents
//  are not reset. A stall on the output holds the sequencer and the chain.
// ----------------------------------------------------------------------------
module positional_array_list_top
    import pal_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic signed [DATA_W-1:0]  o_element,
    output logic [LEN_W-1:0]          o_length,
    output logic                      o_last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TRAV = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_left,  n_left;     // elements still to emit

    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [DATA_W-1:0]  r_element;
    logic [LEN_W-1:0]          r_length;
    logic                      r_last;

    logic                      w_can_load;
    logic                      w_in_acc;
    logic                      w_load;
    t_status                   w_ld_status;
    logic signed [DATA_W-1:0]  w_ld_elem;
    logic [LEN_W-1:0]          w_ld_len;
    logic                      w_ld_last;
    t_cell_ctl                 w_ctl;
    logic [POS_W:0]            w_pos8;
    logic [POS_W:0]            w_cnt8;
    logic signed [DATA_W-1:0]  w_cell [CAPACITY];

    // output register is free when empty or being taken this cycle
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_can_load;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_pos8 = {1'b0, i_position};
    assign w_cnt8 = (POS_W + 1)'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        w_load      = 1'b0;
        w_ld_status = ST_OK;
        w_ld_elem   = '0;
        w_ld_len    = LEN_W'(r_count);
        w_ld_last   = 1'b1;
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.pos   = IDX_W'(i_position - POS_W'(1));
        w_ctl.tail  = IDX_W'(r_count - CNT_W'(1));
        w_ctl.value = i_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_load = 1'b1;
                    unique case (t_op'(i_operation))
                        OP_INSERT: begin
                            // full check comes before the position check
                            if (r_count == CNT_W'(CAPACITY)) begin
                                w_ld_status = ST_FULL;
                            end else if (i_position == '0 ||
                                         w_pos8 > w_cnt8 + (POS_W + 1)'(1)) begin
                                w_ld_status = ST_INVALID;
                            end else begin
                                w_ctl.cmd = CMD_INSERT;
                                n_count   = r_count + CNT_W'(1);
                                w_ld_len  = LEN_W'(r_count + CNT_W'(1));
                            end
                        end
                        OP_DELETE: begin
                            if (i_position == '0 || w_pos8 > w_cnt8) begin
                                w_ld_status = ST_INVALID;
                            end else begin
                                w_ctl.cmd = CMD_DELETE;
                                n_count   = r_count - CNT_W'(1);
                                w_ld_len  = LEN_W'(r_count - CNT_W'(1));
                            end
                        end
                        OP_TRAVERSE: begin
                            if (r_count == '0) begin
                                w_ld_status = ST_EMPTY;
                            end else begin
                                // hand off to the traverse sequencer
                                w_load  = 1'b0;
                                n_state = S_TRAV;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            w_ld_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_TRAV: begin
                if (w_can_load) begin
                    // emit the head cell, rotate the chain by one place
                    w_load    = 1'b1;
                    w_ld_elem = w_cell[0];
                    w_ld_last = (r_left == CNT_W'(1));
                    w_ctl.cmd = CMD_ROTATE;
                    n_left    = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell chain: each cell sees its neighbors and the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        pal_cell u_cell (
            .i_clk      (i_clk),
            .i_cell_idx (IDX_W'(g)),
            .i_ctl      (w_ctl),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_head     (w_cell[0]),
            .o_data     (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= w_ld_status;
            r_element <= w_ld_elem;
            r_length  <= w_ld_len;
            r_last    <= w_ld_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_length    = r_length;
    assign o_last      = r_last;

endmodule

// ===== verif/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker: list tracker and result checker for the positional array list
// Watches both channels. Each accepted item updates a private copy of the
// list and queues the results it must cause. Each accepted result is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pal_checker
    import pal_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [DATA_W-1:0]  i_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                i_status,
    input  logic signed [DATA_W-1:0]  i_element,
    input  logic [LEN_W-1:0]          i_length,
    input  logic                      i_last,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  element;
        logic [LEN_W-1:0]          length;
        logic                      last;
    } t_list_reply;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int unsigned              list_len = 0;
    t_list_reply              list_replies [$];
    t_list_reply              head;
    int                       errors  = 0;
    int                       checked = 0;

    function automatic void list_reply(input t_status st, input logic signed [DATA_W-1:0] el,
                                       input int unsigned len, input logic fin);
        t_list_reply r;
        r.status  = st;
        r.element = el;
        r.length  = LEN_W'(len);
        r.last    = fin;
        list_replies.push_back(r);
    endfunction

    // Apply one item to the tracked list and queue the results it causes.
    function automatic void list_apply(input t_op code, input int unsigned pos,
                                       input logic signed [DATA_W-1:0] val);
        int i;
        case (code)
            OP_INSERT: begin
                // fullness wins over a bad position
                if (list_len >= CAPACITY) begin
                    list_reply(ST_FULL, '0, list_len, 1'b1);
                end else if (pos < 1 || pos > list_len + 1) begin
                    list_reply(ST_INVALID, '0, list_len, 1'b1);
                end else begin
                    for (i = list_len; i >= int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos-1] = val;
                    list_len++;
                    list_reply(ST_OK, '0, list_len, 1'b1);
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    list_reply(ST_INVALID, '0, list_len, 1'b1);
                end else begin
                    for (i = pos - 1; i + 1 < int'(list_len); i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    list_reply(ST_OK, '0, list_len, 1'b1);
                end
            end
            OP_TRAVERSE: begin
                if (list_len == 0) begin
                    list_reply(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < int'(list_len); i++)
                        list_reply(ST_OK, list_mem[i], list_len, i + 1 == int'(list_len));
                end
            end
            default: list_reply(ST_INVALID, '0, list_len, 1'b1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            list_replies.delete();
        end else begin
            // check first: a result never belongs to an item taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (list_replies.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result with nothing due: status %0d element %0d "
                                 , $realtime, i_status, i_element,
                                 "length %0d last %0d", i_length, i_last);
                    errors++;
                end else begin
                    head = list_replies.pop_front();
                    if (i_status !== head.status || i_element !== head.element ||
                        i_length !== head.length || i_last !== head.last) begin
                        if (errors < 10)
                            $display("%0t: mismatch: status %0d/%0d element %0d/%0d ",
                                     $realtime, head.status, i_status, head.element,
                                     i_element, "length %0d/%0d last %0d/%0d (due/seen)",
                                     head.length, i_length, head.last, i_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                list_apply(t_op'(i_operation), i_position, i_value);
        end
        o_errors  <= errors;
        o_pending <= list_replies.size();
        o_checked <= checked;
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the positional array list
// Drives directed edge cases, a bulk load to full capacity, then random
// insert / delete / traverse traffic under four idling phases. The checker
// tracks the list, predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import pal_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic [1:0]                operation  = OP_TRAVERSE;
    logic [POS_W-1:0]          position   = '0;
    logic signed [DATA_W-1:0]  value_in   = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  element;
    logic [LEN_W-1:0]          length;
    logic                      last;

    int errors;
    int pending;
    int checked;

    // Idling control. The sender percentage is used only by the stimulus
    // process; the receiver percentage and hold-off request are read by the
    // stall process, so they are updated with nonblocking assignments.
    int idle_pct     = 0;
    int stall_pct    = 0;
    int holdoff_req  = 0;
    int holdoff_ack  = 0;
    int hold_left    = 0;

    // Stimulus-side view of the list length: only steers positions toward
    // valid ones, it checks nothing.
    int shadow_len   = 0;
    int peak_len     = 0;
    int items_sent   = 0;

    always #2 clk = ~clk;

    positional_array_list_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_operation (operation),
        .i_position  (position),
        .i_value     (value_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_element   (element),
        .o_length    (length),
        .o_last      (last)
    );

    pal_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_operation (operation),
        .i_position  (position),
        .i_value     (value_in),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_status    (status),
        .i_element   (element),
        .i_length    (length),
        .i_last      (last),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Receiver: a pending hold-off request wins and holds stall high for a
    // counted stretch; otherwise stall at random at the phase's rate.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holdoff_req != holdoff_ack) begin
            out_stall   <= 1'b1;
            hold_left   <= HOLDOFF_CYCLES - 1;
            holdoff_ack <= holdoff_req;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offer one item, idling first at the phase's rate, and return at the
    // edge where it is taken. Valid stays high on return so that a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_item(input t_op code, input int pos, input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= code;
        position  <= pos[POS_W-1:0];
        value_in  <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        case (code)
            OP_INSERT: if (shadow_len < CAPACITY && pos >= 1 && pos <= shadow_len + 1)
                           shadow_len++;
            OP_DELETE: if (pos >= 1 && pos <= shadow_len)
                           shadow_len--;
            default: ;
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // Drop valid and hold until every due result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One random item: mostly well-formed inserts and deletes that steer the
    // length toward the target, plus traverses and noise.
    task automatic random_item(input int target);
        int               r;
        int               p;
        t_op              code;
        logic [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        v = $urandom;
        if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        p = $urandom_range(0, 127);
        if (r < 12) begin
            code = OP_TRAVERSE;
        end else if (r < 20) begin
            code = t_op'($urandom_range(0, 3));
        end else if (shadow_len == 0 || shadow_len < target ||
                     (shadow_len == CAPACITY && $urandom_range(0, 3) == 0)) begin
            code = OP_INSERT;
            case ($urandom_range(0, 2))
                0:       p = 1;
                1:       p = shadow_len + 1;
                default: p = $urandom_range(1, shadow_len + 1);
            endcase
        end else begin
            code = OP_DELETE;
            p = $urandom_range(1, shadow_len);
        end
        send_item(code, p, v);
    endtask

    task automatic run_phase(input int sender_idle, input int recv_stall, input int n,
                             input int target);
        idle_pct  = sender_idle;
        stall_pct <= recv_stall;
        repeat (n)
            random_item(target);
        drain();
    endtask

    initial begin
        // hold reset low before releasing it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, bad positions, both value extremes, inserts
        // at front, end and middle, the unused operation, deletes at ends.
        send_item(OP_TRAVERSE, 0, '0);
        send_item(OP_DELETE, 1, '0);
        send_item(OP_INSERT, 0, 32'h1234_5678);
        send_item(OP_INSERT, 2, 32'h1234_5678);
        send_item(OP_INSERT, 1, 32'h8000_0000);
        send_item(OP_INSERT, 2, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 1, 32'h0000_0000);
        send_item(OP_INSERT, 2, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 127, 32'hDEAD_BEEF);
        send_item(OP_UNUSED, 127, 32'hFFFF_FFFF);
        send_item(OP_TRAVERSE, 127, 32'hFFFF_FFFF);
        send_item(OP_DELETE, 0, '0);
        send_item(OP_DELETE, 5, '0);
        send_item(OP_DELETE, 4, '0);
        send_item(OP_DELETE, 1, '0);
        send_item(OP_DELETE, 127, '0);
        send_item(OP_TRAVERSE, 0, '0);
        send_item(OP_INSERT, 3, 32'h5555_5555);
        send_item(OP_INSERT, 2, 32'hAAAA_AAAA);
        send_item(OP_TRAVERSE, 0, '0);
        drain();

        // Bulk load to capacity as end inserts. Hold the receiver off at the
        // same time so results back up and the input side stalls.
        holdoff_req <= holdoff_req + 1;
        while (shadow_len < CAPACITY)
            send_item(OP_INSERT, shadow_len + 1, $urandom);
        send_item(OP_INSERT, 1, 32'h0BAD_F00D);          // full list rejects
        send_item(OP_INSERT, 127, 32'h0BAD_F00D);        // full beats bad position
        send_item(OP_TRAVERSE, 0, '0);                   // longest traverse
        run_phase(0, 0, 10, CAPACITY);

        // random traffic: sender idling, receiver stalling, then both
        run_phase(59, 0, 25, 32);
        run_phase(0, 59, 25, 8);
        run_phase(29, 29, 25, 48);

        // let any trailing activity surface
        repeat (16) @(posedge clk);

        $display("Run covered %0d items (directed cases, a load to %0d entries, random traffic",
                 items_sent, peak_len);
        $display("under four idling phases and a long output hold-off); %0d results checked.",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard limit on run time
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
